@@ design/nrn_pkg.sv @@
// Shared constants and types for the nearest resize normalize core.
package nrn_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 16;

  localparam logic [32:0] RECIP_255 = 33'h101010101;

  localparam logic [2:0] REG_INPUT_HEIGHT    = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH     = 3'd1;
  localparam logic [2:0] REG_INPUT_CHANNELS  = 3'd2;
  localparam logic [2:0] REG_OUTPUT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_OUTPUT_WIDTH    = 3'd4;
  localparam logic [2:0] REG_OUTPUT_CHANNELS = 3'd5;
  localparam logic [2:0] REG_TOTAL_OUTPUTS   = 3'd6;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] waddr;
    logic [15:0] wdata;
    logic        idx_bad;
    logic        zero_dim;
  } side_t;

  typedef struct packed {
    logic        kind;
    logic        bad;
    logic [23:0] src;
  } tail_t;

endpackage

@@ design/nrn_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module nrn_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [nrn_pkg::DIV_NW-1:0]  dividend,
  input  logic [nrn_pkg::DIV_DW-1:0]  divisor,
  output logic [nrn_pkg::DIV_NW-1:0]  quotient,
  output logic [nrn_pkg::DIV_DW-1:0]  remainder
);

  localparam int NW = nrn_pkg::DIV_NW;
  localparam int DW = nrn_pkg::DIV_DW;

  logic [DW-1:0] rem_q     [NW];
  logic [NW-1:0] work_q    [NW];
  logic [DW-1:0] dvs_q     [NW];
  logic [DW-1:0] rem_next  [NW];
  logic [NW-1:0] work_next [NW];
  logic [DW-1:0] dvs_next  [NW];

  always_comb begin
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [NW-1:0] w_in;
    logic [DW:0]   t;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        r_in = '0;
        w_in = dividend;
        d_in = divisor;
      end else begin
        r_in = rem_q[k-1];
        w_in = work_q[k-1];
        d_in = dvs_q[k-1];
      end
      t = {r_in, w_in[NW-1]};
      if (t >= {1'b0, d_in}) begin
        rem_next[k]  = DW'(t - {1'b0, d_in});
        work_next[k] = {w_in[NW-2:0], 1'b1};
      end else begin
        rem_next[k]  = t[DW-1:0];
        work_next[k] = {w_in[NW-2:0], 1'b0};
      end
      dvs_next[k] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        rem_q[k]  <= rem_next[k];
        work_q[k] <= work_next[k];
        dvs_q[k]  <= dvs_next[k];
      end
    end
  end

  assign quotient  = work_q[NW-1];
  assign remainder = rem_q[NW-1];

endmodule

@@ design/nearest_resize_normalize_core.sv @@
// Nearest-neighbor resize with divide-by-255 normalization over an fp16 frame store.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    kind, store_address, sample_bits, out_index
//   out      source     out_valid/out_ready  value_bits, source_address, out_of_range
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word enters per cycle while no output word waits. A fetch result passes two 40-stage
// restoring dividers in series (row split, column and channel split), then two in parallel
// (scaling). Writes travel the same pipe and hit the store in order with the reads.
// Reset returns the registers to their defaults and clears every valid bit; the store keeps
// its contents. While an output word waits, the whole pipe holds and in_ready stays low.
module nearest_resize_normalize_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] store_address,
  input  logic [15:0] sample_bits,
  input  logic [23:0] out_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] value_bits,
  output logic [23:0] source_address,
  output logic        out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int L  = nrn_pkg::DIV_NW;
  localparam int AW = nrn_pkg::ADDR_W;

  typedef enum logic [1:0] {FC_ZERO, FC_NUM, FC_INF, FC_NAN} fclass_t;

  logic [12:0] in_h, in_w, o_h, o_w;
  logic [2:0]  in_c, o_c;
  logic [23:0] total;

  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_h  <= 13'd1;
      in_w  <= 13'd1;
      in_c  <= 3'd1;
      o_h   <= 13'd1;
      o_w   <= 13'd1;
      o_c   <= 3'd1;
      total <= 24'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        nrn_pkg::REG_INPUT_HEIGHT:    in_h  <= cfg_data[12:0];
        nrn_pkg::REG_INPUT_WIDTH:     in_w  <= cfg_data[12:0];
        nrn_pkg::REG_INPUT_CHANNELS:  in_c  <= cfg_data[2:0];
        nrn_pkg::REG_OUTPUT_HEIGHT:   o_h   <= cfg_data[12:0];
        nrn_pkg::REG_OUTPUT_WIDTH:    o_w   <= cfg_data[12:0];
        nrn_pkg::REG_OUTPUT_CHANNELS: o_c   <= cfg_data[2:0];
        nrn_pkg::REG_TOTAL_OUTPUTS:   total <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage
  logic             s0_valid;
  nrn_pkg::side_t   s0_side;
  logic [23:0]      s0_idx;
  logic [15:0]      row_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side.kind     <= kind;
      s0_side.waddr    <= store_address;
      s0_side.wdata    <= sample_bits;
      s0_side.idx_bad  <= out_index >= total;
      s0_side.zero_dim <= (o_h == 13'd0) || (o_w == 13'd0) || (o_c == 3'd0);
      s0_idx           <= out_index;
    end
  end

  assign row_len = {3'b0, o_w} * {13'b0, o_c};

  // row split
  logic [L-1:0]  q1, q2, q3, q4;
  logic [15:0]   r1, r2, r3, r4;

  nrn_div u_div_row (
    .clk(clk), .en(en), .dividend({16'b0, s0_idx}), .divisor(row_len),
    .quotient(q1), .remainder(r1)
  );

  logic [L-1:0]   va;
  nrn_pkg::side_t da [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else if (en) begin
      va <= {va[L-2:0], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da[0] <= s0_side;
      for (int k = 1; k < L; k++) da[k] <= da[k-1];
    end
  end

  // column and channel split
  nrn_div u_div_col (
    .clk(clk), .en(en), .dividend({24'b0, r1}), .divisor({13'b0, o_c}),
    .quotient(q2), .remainder(r2)
  );

  logic [L-1:0]   vb;
  nrn_pkg::side_t db [L];
  logic [23:0]    oyb [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[L-2:0], va[L-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db[0]  <= da[L-1];
      oyb[0] <= q1[23:0];
      for (int k = 1; k < L; k++) begin
        db[k]  <= db[k-1];
        oyb[k] <= oyb[k-1];
      end
    end
  end

  // scale numerators
  logic           m_valid;
  nrn_pkg::side_t m_side;
  logic [36:0]    m_ny;
  logic [28:0]    m_nx;
  logic [2:0]     m_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= vb[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side <= db[L-1];
      m_ny   <= {13'b0, oyb[L-1]} * {24'b0, in_h};
      m_nx   <= {13'b0, q2[15:0]} * {16'b0, in_w};
      m_c    <= r2[2:0];
    end
  end

  nrn_div u_div_y (
    .clk(clk), .en(en), .dividend({3'b0, m_ny}), .divisor({3'b0, o_h}),
    .quotient(q3), .remainder(r3)
  );

  nrn_div u_div_x (
    .clk(clk), .en(en), .dividend({11'b0, m_nx}), .divisor({3'b0, o_w}),
    .quotient(q4), .remainder(r4)
  );

  logic [L-1:0]   vc;
  nrn_pkg::side_t dc [L];
  logic [2:0]     cc [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= '0;
    end else if (en) begin
      vc <= {vc[L-2:0], m_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc[0] <= m_side;
      cc[0] <= m_c;
      for (int k = 1; k < L; k++) begin
        dc[k] <= dc[k-1];
        cc[k] <= cc[k-1];
      end
    end
  end

  // source address
  logic           p1_valid, p2_valid, p3_valid;
  nrn_pkg::side_t p1_side, p2_side;
  logic [49:0]    p1_t;
  logic [28:0]    p1_sx;
  logic [2:0]     p1_c, p2_c;
  logic [50:0]    p2_u;
  logic [53:0]    src_full;
  logic [31:0]    waddr_ext;
  logic           p3_we;
  logic [AW-1:0]  p3_addr;
  logic [15:0]    p3_wdata;
  nrn_pkg::tail_t p3_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= vc[L-1];
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
    end
  end

  assign src_full  = {3'b0, p2_u} * {51'b0, in_c} + {51'b0, p2_c};
  assign waddr_ext = {16'b0, p2_side.waddr};

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side <= dc[L-1];
      p1_c    <= cc[L-1];
      p1_t    <= {13'b0, q3[36:0]} * {37'b0, in_w};
      p1_sx   <= q4[28:0];
      p2_side <= p1_side;
      p2_c    <= p1_c;
      p2_u    <= {1'b0, p1_t} + {22'b0, p1_sx};
      p3_tail.kind <= p2_side.kind;
      p3_tail.bad  <= p2_side.idx_bad || p2_side.zero_dim ||
                      (src_full >= 54'(nrn_pkg::STORE_DEPTH));
      p3_tail.src  <= p2_side.zero_dim ? 24'd0 : src_full[23:0];
      p3_we        <= (p2_side.kind == nrn_pkg::KIND_WRITE) &&
                      (waddr_ext < 32'(nrn_pkg::STORE_DEPTH));
      p3_addr      <= (p2_side.kind == nrn_pkg::KIND_FETCH) ? src_full[AW-1:0]
                                                            : waddr_ext[AW-1:0];
      p3_wdata     <= p2_side.wdata;
    end
  end

  // frame store
  logic [15:0]    mem [nrn_pkg::STORE_DEPTH];
  logic           r_valid;
  nrn_pkg::tail_t r_tail;
  logic [15:0]    r_data;

  always_ff @(posedge clk) begin
    if (en) begin
      if (p3_valid && p3_we) mem[p3_addr] <= p3_wdata;
      r_data <= mem[p3_addr];
      r_tail <= p3_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= p3_valid;
    end
  end

  // fp16 decode
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  h_msb, h_lz;
  fclass_t     h_cls;
  logic [10:0] h_man11;
  logic [6:0]  h_e;

  assign h_exp = r_data[14:10];
  assign h_man = r_data[9:0];

  always_comb begin
    h_msb = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) h_msb = 4'(i);
    end
    h_lz = 4'd10 - h_msb;
    if (h_exp == 5'd31) begin
      h_cls   = (h_man != 10'd0) ? FC_NAN : FC_INF;
      h_man11 = {1'b1, h_man};
      h_e     = 7'd31;
    end else if (h_exp == 5'd0) begin
      h_cls   = (h_man == 10'd0) ? FC_ZERO : FC_NUM;
      h_man11 = {1'b0, h_man} << h_lz;
      h_e     = 7'd1 - {3'b0, h_lz};
    end else begin
      h_cls   = FC_NUM;
      h_man11 = {1'b1, h_man};
      h_e     = {2'b0, h_exp};
    end
  end

  logic           f1_valid, f2_valid, f3_valid, f4_valid;
  nrn_pkg::tail_t f1_tail, f2_tail, f3_tail, f4_tail;
  logic           f1_sign, f2_sign, f3_sign, f4_sign;
  fclass_t        f1_cls, f2_cls, f3_cls, f4_cls;
  logic [6:0]     f1_e, f2_e, f3_e;
  logic [10:0]    f1_man, f2_man;
  logic [25:0]    f2_q, f3_q;
  logic           f3_stk;
  logic [7:0]     f4_e32;
  logic [22:0]    f4_m23;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= r_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
    end
  end

  // quotient estimate by reciprocal
  logic [43:0] prod;
  assign prod = {33'b0, f1_man} * {11'b0, nrn_pkg::RECIP_255};

  // remainder correction
  logic [33:0] n34, p34, r34;
  logic [25:0] q_fix;
  logic        stk_fix;

  assign n34 = {1'b0, f2_man, 22'b0};
  assign p34 = {f2_q, 8'b0} - {8'b0, f2_q};
  assign r34 = n34 - p34;

  always_comb begin
    if (r34 >= 34'd255) begin
      q_fix   = f2_q + 26'd1;
      stk_fix = (r34 - 34'd255) != 34'd0;
    end else begin
      q_fix   = f2_q;
      stk_fix = r34 != 34'd0;
    end
  end

  // round to binary32
  logic [23:0] sig;
  logic        g_bit, s_bit, inc;
  logic [24:0] sig_r;
  logic [8:0]  e9;

  always_comb begin
    if (f3_q[25]) begin
      sig   = f3_q[25:2];
      g_bit = f3_q[1];
      s_bit = f3_q[0] || f3_stk;
      e9    = {{2{f3_e[6]}}, f3_e} + 9'd105;
    end else begin
      sig   = f3_q[24:1];
      g_bit = f3_q[0];
      s_bit = f3_stk;
      e9    = {{2{f3_e[6]}}, f3_e} + 9'd104;
    end
    inc   = g_bit && (s_bit || sig[0]);
    sig_r = {1'b0, sig} + {24'b0, inc};
    if (sig_r[24]) e9 = e9 + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tail <= r_tail;
      f1_sign <= r_data[15];
      f1_cls  <= h_cls;
      f1_e    <= h_e;
      f1_man  <= h_man11;
      f2_tail <= f1_tail;
      f2_sign <= f1_sign;
      f2_cls  <= f1_cls;
      f2_e    <= f1_e;
      f2_man  <= f1_man;
      f2_q    <= prod[43:18];
      f3_tail <= f2_tail;
      f3_sign <= f2_sign;
      f3_cls  <= f2_cls;
      f3_e    <= f2_e;
      f3_q    <= q_fix;
      f3_stk  <= stk_fix;
      f4_tail <= f3_tail;
      f4_sign <= f3_sign;
      f4_cls  <= f3_cls;
      f4_e32  <= e9[7:0];
      f4_m23  <= sig_r[24] ? sig_r[23:1] : sig_r[22:0];
    end
  end

  // round to fp16
  logic signed [9:0] hh, sh;
  logic [23:0]       full;
  logic [10:0]       rn;
  logic [11:0]       rn_r;
  logic [12:0]       rem13;
  logic [25:0]       full26, rsub, mask, rem26, half26;
  logic [4:0]        sh5;
  logic [14:0]       mag;
  logic [15:0]       val;

  always_comb begin
    hh     = $signed({2'b0, f4_e32}) - 10'sd112;
    sh     = 10'sd14 - hh;
    sh5    = sh[4:0];
    full   = {1'b1, f4_m23};
    full26 = {2'b0, full};
    rn     = full[23:13];
    rem13  = full[12:0];
    rn_r   = {1'b0, rn};
    rsub   = full26 >> sh5;
    mask   = (26'd1 << sh5) - 26'd1;
    rem26  = full26 & mask;
    half26 = 26'd1 << (sh5 - 5'd1);
    mag    = 15'd0;
    if (hh >= 10'sd31) begin
      mag = 15'h7C00;
    end else if (hh >= 10'sd1) begin
      if (rem13 > 13'h1000 || (rem13 == 13'h1000 && rn[0])) rn_r = rn_r + 12'd1;
      if (rn_r[11]) begin
        if (hh + 10'sd1 >= 10'sd31) mag = 15'h7C00;
        else mag = {hh[4:0] + 5'd1, 10'd0};
      end else begin
        mag = {hh[4:0], rn_r[9:0]};
      end
    end else if (sh <= 10'sd25) begin
      if (rem26 > half26 || (rem26 == half26 && rsub[0])) rsub = rsub + 26'd1;
      mag = rsub[14:0];
    end
    case (f4_cls)
      FC_ZERO: val = {f4_sign, 15'd0};
      FC_INF:  val = {f4_sign, 15'h7C00};
      FC_NAN:  val = {f4_sign, 15'h7E00};
      default: val = {f4_sign, mag};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f4_valid && (f4_tail.kind == nrn_pkg::KIND_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_bits     <= f4_tail.bad ? 16'd0 : val;
      source_address <= f4_tail.src;
      out_of_range   <= f4_tail.bad;
    end
  end

endmodule

@@ design/nrn_check.sv @@
// Port-level assertions for the nearest resize normalize core, with bind.
module nrn_check (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] value_bits,
  input logic [23:0] source_address,
  input logic        out_of_range
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output word waits");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> value_bits == 16'd0)
    else $error("flagged word carries a value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_bits) &&
    $stable(source_address) && $stable(out_of_range))
    else $error("stalled output word changed");

endmodule

bind nearest_resize_normalize_core nrn_check u_nrn_check (.*);

@@ sim/nearest_resize_normalize_core_test.sv @@
// Self-checking testbench for the nearest resize normalize core.
module nearest_resize_normalize_core_test;

  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_ITEMS  = 1700;

  typedef struct {
    logic [15:0] value;
    logic [23:0] src;
    logic        oor;
  } fetch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = nrn_pkg::KIND_WRITE;
  logic [15:0] store_address = '0;
  logic [15:0] sample_bits = '0;
  logic [23:0] out_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] value_bits;
  logic [23:0] source_address;
  logic        out_of_range;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  nearest_resize_normalize_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [15:0] store_img [0:nrn_pkg::STORE_DEPTH-1];
  bit          written [0:nrn_pkg::STORE_DEPTH-1];
  longint unsigned in_h = 1, in_w = 1, in_c = 1, out_h = 1, out_w = 1, out_c = 1, total = 0;
  fetch_result_t pending_results[$];
  int errors = 0;
  int items = 0;
  int burst_left = 8;
  int gap_left = 0;
  int cyc = 0;
  int stall_mode = 0;

  logic [15:0] specials [13] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7D01,
                                 16'hFE00, 16'h0001, 16'h03FF, 16'h7BFF, 16'hFBFF, 16'h3C00,
                                 16'h5BF8};

  // fp16 sample divided by 255 in binary32 (RNE), then rounded to fp16 (RNE)
  function automatic logic [15:0] normalize_sample(input logic [15:0] h);
    logic [15:0] s;
    int ex, man, fe, m23, hexp, shift, r, rem, half;
    real v, q;
    logic [63:0] d;
    longint unsigned rem29;
    s = {h[15], 15'd0};
    ex = h[14:10];
    man = h[9:0];
    if (ex == 31) return s | ((man != 0) ? 16'h7E00 : 16'h7C00);
    if (ex == 0 && man == 0) return s;
    if (ex == 0) v = man * (2.0 ** (-24));
    else v = (1024 + man) * (2.0 ** (ex - 25));
    q = v / 255.0;
    d = $realtobits(q);
    fe = int'(d[62:52]) - 1023 + 127;
    m23 = d[51:29];
    rem29 = d[28:0];
    if (rem29 > 64'h1000_0000 || (rem29 == 64'h1000_0000 && m23[0])) begin
      m23 = m23 + 1;
      if (m23 == (1 << 23)) begin
        m23 = 0;
        fe = fe + 1;
      end
    end
    m23 = m23 | (1 << 23);
    hexp = fe - 112;
    if (hexp >= 31) return s | 16'h7C00;
    if (hexp >= 1) begin
      r = m23 >> 13;
      rem = m23 & 'h1FFF;
      if (rem > 'h1000 || (rem == 'h1000 && r[0])) r = r + 1;
      if (r == 'h800) begin
        r = r >> 1;
        hexp = hexp + 1;
      end
      if (hexp >= 31) return s | 16'h7C00;
      return s | 16'(hexp << 10) | 16'(r & 'h3FF);
    end
    shift = 14 - hexp;
    if (shift > 25) return s;
    r = m23 >> shift;
    rem = m23 & ((1 << shift) - 1);
    half = 1 << (shift - 1);
    if (rem > half || (rem == half && r[0])) r = r + 1;
    return s | 16'(r);
  endfunction

  function automatic void locate_source(input logic [23:0] x, output longint unsigned src,
                                        output logic zero_dim);
    longint unsigned rl, oy, rm, ox, c, sy, sx;
    zero_dim = (out_h == 0 || out_w == 0 || out_c == 0);
    src = 0;
    if (zero_dim) return;
    rl = out_w * out_c;
    oy = x / rl;
    rm = x % rl;
    ox = rm / out_c;
    c = rm % out_c;
    sy = oy * in_h / out_h;
    sx = ox * in_w / out_w;
    src = (sy * in_w + sx) * in_c + c;
  endfunction

  function automatic fetch_result_t resize_fetch(input logic [23:0] x);
    fetch_result_t r;
    longint unsigned src;
    logic zd, bad;
    locate_source(x, src, zd);
    if (zd) begin
      r.value = '0;
      r.src = '0;
      r.oor = 1'b1;
      return r;
    end
    bad = (x >= total) || (src >= nrn_pkg::STORE_DEPTH);
    r.value = bad ? 16'h0000 : normalize_sample(store_img[src]);
    r.src = src[23:0];
    r.oor = bad;
    return r;
  endfunction

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(0, 5) == 0) return specials[$urandom_range(0, 12)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_word(input logic k, input logic [15:0] a, input logic [15:0] d,
                           input logic [23:0] x);
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_valid <= 1'b1;
    kind <= k;
    store_address <= a;
    sample_bits <= d;
    out_index <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k == nrn_pkg::KIND_WRITE) begin
      store_img[a] = d;
      written[a] = 1'b1;
    end else begin
      pending_results.push_back(resize_fetch(x));
    end
    items++;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(100, 300);
        gap_left = 0;
      end else begin
        burst_left = $urandom_range(1, 20);
        gap_left = $urandom_range(1, 7);
      end
    end
  endtask

  task automatic write_sample(input logic [15:0] a, input logic [15:0] d);
    send_word(nrn_pkg::KIND_WRITE, a, d, 24'($urandom()));
  endtask

  // store a sample first where the fetch would read an empty entry
  task automatic fetch_output(input logic [23:0] x);
    longint unsigned src;
    logic zd;
    locate_source(x, src, zd);
    if (!zd && x < total && src < nrn_pkg::STORE_DEPTH && !written[src])
      write_sample(src[15:0], rand_sample());
    send_word(nrn_pkg::KIND_FETCH, 16'($urandom()), 16'($urandom()), x);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    gap_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] i, input logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (i)
      nrn_pkg::REG_INPUT_HEIGHT:    in_h = d[12:0];
      nrn_pkg::REG_INPUT_WIDTH:     in_w = d[12:0];
      nrn_pkg::REG_INPUT_CHANNELS:  in_c = d[2:0];
      nrn_pkg::REG_OUTPUT_HEIGHT:   out_h = d[12:0];
      nrn_pkg::REG_OUTPUT_WIDTH:    out_w = d[12:0];
      nrn_pkg::REG_OUTPUT_CHANNELS: out_c = d[2:0];
      nrn_pkg::REG_TOTAL_OUTPUTS:   total = d;
      default: ;
    endcase
  endtask

  task automatic configure(input int ih, input int iw, input int ic, input int oh,
                           input int ow, input int oc, input int tot);
    settle();
    put_reg(nrn_pkg::REG_INPUT_HEIGHT, 24'(ih));
    put_reg(nrn_pkg::REG_INPUT_WIDTH, 24'(iw));
    put_reg(nrn_pkg::REG_INPUT_CHANNELS, 24'(ic));
    put_reg(nrn_pkg::REG_OUTPUT_HEIGHT, 24'(oh));
    put_reg(nrn_pkg::REG_OUTPUT_WIDTH, 24'(ow));
    put_reg(nrn_pkg::REG_OUTPUT_CHANNELS, 24'(oc));
    put_reg(nrn_pkg::REG_TOTAL_OUTPUTS, 24'(tot));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_special_samples();
    configure(4, 4, 4, 4, 4, 4, 64);
    for (int i = 0; i < 13; i++) begin
      write_sample(16'(i), specials[i]);
      fetch_output(24'(i));
    end
    fetch_output(24'd63);
    fetch_output(24'd64);
    fetch_output(24'hFFFFFF);
  endtask

  task automatic test_scaling();
    configure(3, 5, 3, 7, 2, 2, 28);
    for (int i = 0; i < 30; i++) fetch_output(24'(i));
    configure(9, 11, 2, 4, 3, 1, 12);
    for (int i = 0; i < 13; i++) fetch_output(24'(i));
  endtask

  task automatic test_extremes();
    configure(4096, 4096, 4, 4096, 4096, 4, 24'hFFFFFF);
    fetch_output(24'd0);
    fetch_output(24'd3);
    fetch_output(24'hFFFFFE);
    fetch_output(24'hFFFFFF);
    configure(8191, 8191, 7, 1, 1, 7, 0);
    fetch_output(24'd0);
    fetch_output(24'hFFFFFF);
    configure(2, 2, 2, 0, 3, 2, 10);
    fetch_output(24'd1);
    configure(2, 2, 2, 2, 0, 2, 10);
    fetch_output(24'd1);
    configure(2, 2, 2, 2, 3, 0, 10);
    fetch_output(24'd1);
    configure(0, 0, 0, 1, 1, 1, 1);
    fetch_output(24'd0);
    // more output channels than stored
    configure(2, 2, 1, 2, 2, 4, 16);
    for (int i = 0; i < 17; i++) fetch_output(24'(i));
  endtask

  task automatic test_random();
    int ih, iw, ic, oh, ow, oc, tot, span, phase;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      ih = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 4096) : $urandom_range(1, 16);
      iw = $urandom_range(1, 16);
      ic = $urandom_range(1, 4);
      oh = $urandom_range(1, 24);
      ow = $urandom_range(1, 24);
      oc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(1, ic);
      tot = oh * ow * oc;
      if ($urandom_range(0, 4) == 0) tot = $urandom_range(0, tot + 8);
      configure(ih, iw, ic, oh, ow, oc, tot);
      span = ih * iw * ic;
      if (span > nrn_pkg::STORE_DEPTH) span = nrn_pkg::STORE_DEPTH;
      for (int n = 0; n < 120; n++) begin
        if (n == 60 && phase % 3 == 0) wait_drained();
        case ($urandom_range(0, 19))
          0:         write_sample(16'($urandom()), rand_sample());
          1, 2, 3:   write_sample(16'($urandom_range(0, span - 1)), rand_sample());
          4:         fetch_output(24'($urandom()));
          default:   fetch_output(24'($urandom_range(0, tot + 2)));
        endcase
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= (cyc % 16 >= 5);
      endcase
    end
  end

  always @(posedge clk) begin
    fetch_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: value_bits %h source_address %h out_of_range %b",
               value_bits, source_address, out_of_range);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (value_bits !== e.value) begin
          $error("value_bits expected %h actual %h", e.value, value_bits);
          errors++;
        end
        if (source_address !== e.src) begin
          $error("source_address expected %h actual %h", e.src, source_address);
          errors++;
        end
        if (out_of_range !== e.oor) begin
          $error("out_of_range expected %b actual %b", e.oor, out_of_range);
          errors++;
        end
      end
    end
  end

  initial begin
    #12000000;
    $display("nearest_resize_normalize_core_test NOT OK");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_samples();
    test_scaling();
    test_extremes();
    test_random();
    settle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("nearest_resize_normalize_core_test OK");
    end else begin
      $display("nearest_resize_normalize_core_test NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/nrn_pkg.sv
design/nrn_div.sv
design/nearest_resize_normalize_core.sv
design/nrn_check.sv
sim/nearest_resize_normalize_core_test.sv
